>>> hw/rtl/spherical_uv_mapper_unit_defines.svh
// ----------------------------------------------------------------------------
// Spherical UV mapper assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_UV_MAPPER_UNIT_DEFINES_SVH
`define SPHERICAL_UV_MAPPER_UNIT_DEFINES_SVH

// same-cycle implication
`define SUM_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define SUM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/suvm_pkg.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper package
// Payload types, datapath widths, angle constants and CORDIC helpers.
// ----------------------------------------------------------------------------
package suvm_pkg;

    localparam int IN_WIDTH  = 24;
    localparam int OUT_WIDTH = 16;
    localparam int DW        = 64;
    localparam int AW        = 38;
    localparam int GUARD     = 60 - IN_WIDTH;

    typedef logic signed [DW-1:0] dat_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef logic [OUT_WIDTH-1:0] frac_t;

    localparam ang_t HALF_TURN    = 38'sd2147483648;
    localparam ang_t QUARTER_TURN = 38'sd1073741824;
    localparam frac_t FRAC_HALF   = frac_t'(1) << (OUT_WIDTH - 1);
    localparam frac_t FRAC_MAX    = '1;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] vec_x;
        logic signed [IN_WIDTH-1:0] vec_y;
        logic signed [IN_WIDTH-1:0] vec_z;
    } vec_t;

    typedef struct packed {
        frac_t coord_u;
        frac_t coord_v;
        logic  zero_vector_error;
    } coord_t;

    // atan(2^-s), 2^32 units per turn
    function automatic ang_t atan_ang(input logic [4:0] s);
        logic [29:0] a;
        case (s)
            5'd0:  a = 30'h20000000;
            5'd1:  a = 30'h12E4051E;
            5'd2:  a = 30'h09FB385B;
            5'd3:  a = 30'h051111D4;
            5'd4:  a = 30'h028B0D43;
            5'd5:  a = 30'h0145D7E1;
            5'd6:  a = 30'h00A2F61E;
            5'd7:  a = 30'h00517C55;
            5'd8:  a = 30'h0028BE53;
            5'd9:  a = 30'h00145F2F;
            5'd10: a = 30'h000A2F98;
            5'd11: a = 30'h000517CC;
            5'd12: a = 30'h00028BE6;
            5'd13: a = 30'h000145F3;
            5'd14: a = 30'h0000A2FA;
            5'd15: a = 30'h0000517D;
            5'd16: a = 30'h000028BE;
            5'd17: a = 30'h0000145F;
            5'd18: a = 30'h00000A30;
            5'd19: a = 30'h00000518;
            5'd20: a = 30'h0000028C;
            5'd21: a = 30'h00000146;
            5'd22: a = 30'h000000A3;
            5'd23: a = 30'h00000051;
            5'd24: a = 30'h00000029;
            5'd25: a = 30'h00000014;
            5'd26: a = 30'h0000000A;
            5'd27: a = 30'h00000005;
            5'd28: a = 30'h00000003;
            5'd29: a = 30'h00000001;
            5'd30: a = 30'h00000001;
            default: a = 30'h00000000;
        endcase
        return ang_t'({8'd0, a});
    endfunction

    // 2^-32 units of 1.0 to rounded, saturated fraction
    function automatic frac_t to_frac(input ang_t full);
        ang_t r;
        frac_t f;
        r = (full + (ang_t'(1) <<< (31 - OUT_WIDTH))) >>> (32 - OUT_WIDTH);
        if (full <= 0)
            f = '0;
        else if (r > ang_t'({1'b0, FRAC_MAX}))
            f = FRAC_MAX;
        else
            f = r[OUT_WIDTH-1:0];
        return f;
    endfunction

endpackage

>>> hw/rtl/spherical_uv_mapper_unit.sv
// ----------------------------------------------------------------------------
// Spherical UV mapper
// Equirectangular (u, v) from a signed 3D vector by pipelined CORDIC vectoring.
// ----------------------------------------------------------------------------
//  channel | signals                    | payload
//  --------+----------------------------+-----------------------------------
//  input   | vec_valid / vec_ready      | vec   (vec_x, vec_y, vec_z)
//  output  | coord_valid / coord_ready  | coord (coord_u, coord_v, error)
//
//  One transaction per cycle sustained while the output is not stalled; data
//  passes the azimuth/gain CORDIC chain, then the polar CORDIC chain.
//  rst_n clears all stage valid bits; payload registers are not reset.
//  A stalled output freezes the whole pipeline; vec_ready drops with it.
// ----------------------------------------------------------------------------
module spherical_uv_mapper_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vec_valid,
    output logic            vec_ready,
    input  suvm_pkg::vec_t  vec,
    output logic            coord_valid,
    input  logic            coord_ready,
    output suvm_pkg::coord_t coord
);
    import suvm_pkg::*;
    `include "spherical_uv_mapper_unit_defines.svh"

    localparam int N = CORDIC_STAGES;

    logic en;

    // azimuth / z-gain chain, index 0 is the input stage
    logic  a_vld_reg  [0:N];
    dat_t  a_x_reg    [0:N];
    dat_t  a_y_reg    [0:N];
    ang_t  a_t_reg    [0:N];
    dat_t  z_x_reg    [0:N];
    dat_t  z_y_reg    [0:N];
    logic  zneg_reg   [0:N];
    logic  axis_reg   [0:N];
    logic  zero_reg   [0:N];

    // polar chain, index 0 is the pre-rotation stage
    logic  p_vld_reg  [0:N];
    dat_t  p_x_reg    [0:N];
    dat_t  p_y_reg    [0:N];
    ang_t  p_t_reg    [0:N];
    frac_t p_u_reg    [0:N];
    logic  p_zero_reg [0:N];

    logic   out_vld_reg;
    coord_t out_reg;

    dat_t in_x, in_y, in_z;
    dat_t zs;
    ang_t phi2;

    assign en        = !out_vld_reg || coord_ready;
    assign vec_ready = en;

    assign in_x = dat_t'(vec.vec_x) <<< GUARD;
    assign in_y = dat_t'(vec.vec_y) <<< GUARD;
    assign in_z = dat_t'(vec.vec_z) <<< GUARD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg[0] <= vec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_x < 0)
            begin
                a_x_reg[0] <= -in_x;
                a_y_reg[0] <= -in_y;
                a_t_reg[0] <= (in_y >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                a_x_reg[0] <= in_x;
                a_y_reg[0] <= in_y;
                a_t_reg[0] <= '0;
            end
            z_x_reg[0]  <= (in_z < 0) ? -in_z : in_z;
            z_y_reg[0]  <= '0;
            zneg_reg[0] <= in_z < 0;
            axis_reg[0] <= (in_x == 0) && (in_y == 0);
            zero_reg[0] <= (in_x == 0) && (in_y == 0) && (in_z == 0);
        end
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_az
        localparam int S = i - 1;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                a_vld_reg[i] <= a_vld_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!a_y_reg[i-1][DW-1])
                begin
                    a_x_reg[i] <= a_x_reg[i-1] + (a_y_reg[i-1] >>> S);
                    a_y_reg[i] <= a_y_reg[i-1] - (a_x_reg[i-1] >>> S);
                    a_t_reg[i] <= a_t_reg[i-1] + atan_ang(5'(S));
                end
                else
                begin
                    a_x_reg[i] <= a_x_reg[i-1] - (a_y_reg[i-1] >>> S);
                    a_y_reg[i] <= a_y_reg[i-1] + (a_x_reg[i-1] >>> S);
                    a_t_reg[i] <= a_t_reg[i-1] - atan_ang(5'(S));
                end
                if (!z_y_reg[i-1][DW-1])
                begin
                    z_x_reg[i] <= z_x_reg[i-1] + (z_y_reg[i-1] >>> S);
                    z_y_reg[i] <= z_y_reg[i-1] - (z_x_reg[i-1] >>> S);
                end
                else
                begin
                    z_x_reg[i] <= z_x_reg[i-1] - (z_y_reg[i-1] >>> S);
                    z_y_reg[i] <= z_y_reg[i-1] + (z_x_reg[i-1] >>> S);
                end
                zneg_reg[i] <= zneg_reg[i-1];
                axis_reg[i] <= axis_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    assign zs = zneg_reg[N] ? -z_x_reg[N] : z_x_reg[N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg[0] <= a_vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zs < 0)
            begin
                p_t_reg[0] <= QUARTER_TURN;
                p_x_reg[0] <= a_x_reg[N];
                p_y_reg[0] <= -zs;
            end
            else
            begin
                p_t_reg[0] <= '0;
                p_x_reg[0] <= zs;
                p_y_reg[0] <= a_x_reg[N];
            end
            p_u_reg[0]    <= axis_reg[N] ? FRAC_HALF : to_frac(a_t_reg[N] + HALF_TURN);
            p_zero_reg[0] <= zero_reg[N];
        end
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_pol
        localparam int S = i - 1;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                p_vld_reg[i] <= p_vld_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!p_y_reg[i-1][DW-1])
                begin
                    p_x_reg[i] <= p_x_reg[i-1] + (p_y_reg[i-1] >>> S);
                    p_y_reg[i] <= p_y_reg[i-1] - (p_x_reg[i-1] >>> S);
                    p_t_reg[i] <= p_t_reg[i-1] + atan_ang(5'(S));
                end
                else
                begin
                    p_x_reg[i] <= p_x_reg[i-1] - (p_y_reg[i-1] >>> S);
                    p_y_reg[i] <= p_y_reg[i-1] + (p_x_reg[i-1] >>> S);
                    p_t_reg[i] <= p_t_reg[i-1] - atan_ang(5'(S));
                end
                p_u_reg[i]    <= p_u_reg[i-1];
                p_zero_reg[i] <= p_zero_reg[i-1];
            end
        end
    end

    assign phi2 = p_t_reg[N] <<< 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= p_vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (p_zero_reg[N])
            begin
                out_reg.coord_u <= '0;
                out_reg.coord_v <= '0;
            end
            else
            begin
                out_reg.coord_u <= p_u_reg[N];
                out_reg.coord_v <= to_frac(phi2);
            end
            out_reg.zero_vector_error <= p_zero_reg[N];
        end
    end

    assign coord_valid = out_vld_reg;
    assign coord       = out_reg;

    `SUM_ASSERT_IMPL(a_zero_out, coord_valid && coord.zero_vector_error,
        coord.coord_u == '0 && coord.coord_v == '0)
    `SUM_ASSERT_IMPL(a_zero_in, a_vld_reg[0] && zero_reg[0],
        axis_reg[0] && z_x_reg[0] == '0)
    `SUM_ASSERT_NEXT(a_stall_hold, coord_valid && !coord_ready,
        $stable(p_vld_reg[N]) && $stable(a_vld_reg[N]) && $stable(p_u_reg[N]))

endmodule
